// ----- rtl/core/ppc_pkg.sv -----
`default_nettype none

package ppc_pkg;

    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;
    localparam int COORD_W        = 32;
    localparam int NORMAL_W       = 16;
    localparam int OFFSET_W       = 32;
    localparam int TOL_W          = 31;
    localparam int FRAC_SHIFT     = 14;
    localparam int PROD_W         = COORD_W + NORMAL_W;
    localparam int DIST_W         = PROD_W + 4;
    localparam int SIDE_W         = 2;
    localparam int S_TDATA_W      = 3 * COORD_W;
    localparam int M_TDATA_W      = 8;
    localparam int PPC_FIFO_DEPTH = 4;

    localparam logic [2:0] REG_NORMAL_X     = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y     = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z     = 3'd2;
    localparam logic [2:0] REG_PLANE_OFFSET = 3'd3;
    localparam logic [2:0] REG_TOLERANCE    = 3'd4;

    localparam logic [SIDE_W-1:0] SIDE_FRONT    = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_BACK     = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_COPLANAR = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_CROSSING = 2'd3;

    localparam logic signed [NORMAL_W-1:0] NORMAL_X_RST = 16'sd0;
    localparam logic signed [NORMAL_W-1:0] NORMAL_Y_RST = 16'sd0;
    localparam logic signed [NORMAL_W-1:0] NORMAL_Z_RST = 16'sd16384;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST   = 32'sd0;
    localparam logic [TOL_W-1:0]           TOL_RST      = 31'd66;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic signed [OFFSET_W-1:0] plane_offset;
        logic [TOL_W-1:0]           tolerance;
    } cfg_t;

    // classified vertex handed from front to back
    typedef struct packed {
        logic above;
        logic below;
        logic last;
    } vclass_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppc_cfg.sv -----
`default_nettype none

module ppc_cfg
    import ppc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_NORMAL_X:     cfg_next.normal_x     = pwdata[NORMAL_W-1:0];
                REG_NORMAL_Y:     cfg_next.normal_y     = pwdata[NORMAL_W-1:0];
                REG_NORMAL_Z:     cfg_next.normal_z     = pwdata[NORMAL_W-1:0];
                REG_PLANE_OFFSET: cfg_next.plane_offset = pwdata[OFFSET_W-1:0];
                REG_TOLERANCE:    cfg_next.tolerance    = pwdata[TOL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NORMAL_X:     prdata = {{(APB_DATA_W-NORMAL_W){1'b0}}, cfg_reg.normal_x};
            REG_NORMAL_Y:     prdata = {{(APB_DATA_W-NORMAL_W){1'b0}}, cfg_reg.normal_y};
            REG_NORMAL_Z:     prdata = {{(APB_DATA_W-NORMAL_W){1'b0}}, cfg_reg.normal_z};
            REG_PLANE_OFFSET: prdata = cfg_reg.plane_offset;
            REG_TOLERANCE:    prdata = {{(APB_DATA_W-TOL_W){1'b0}}, cfg_reg.tolerance};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal_x     <= NORMAL_X_RST;
            cfg_reg.normal_y     <= NORMAL_Y_RST;
            cfg_reg.normal_z     <= NORMAL_Z_RST;
            cfg_reg.plane_offset <= OFFSET_RST;
            cfg_reg.tolerance    <= TOL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ppc_front.sv -----
`default_nettype none

module ppc_front
    import ppc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  cfg_t                      cfg,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 q_full,
    output logic                      q_push,
    output vclass_t                   q_item
);

    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;

    // stage 1: products
    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] pz_reg;

    // stage 2: distance in Q.14
    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic signed [DIST_W-1:0] dist_next;
    logic signed [DIST_W-1:0] offset_scaled;
    logic signed [DIST_W-1:0] band;

    logic en;

    assign vx = s_tdata[COORD_W-1:0];
    assign vy = s_tdata[2*COORD_W-1:COORD_W];
    assign vz = s_tdata[3*COORD_W-1:2*COORD_W];

    assign en       = !s2_valid_reg || !q_full;
    assign s_tready = en;

    assign offset_scaled = DIST_W'(cfg.plane_offset) <<< FRAC_SHIFT;
    assign dist_next     = DIST_W'(px_reg) + DIST_W'(py_reg) + DIST_W'(pz_reg)
                           - offset_scaled;
    assign band = {{(DIST_W-TOL_W-FRAC_SHIFT){1'b0}}, cfg.tolerance, {FRAC_SHIFT{1'b0}}};

    assign q_push       = s2_valid_reg && !q_full;
    assign q_item.above = dist_reg > band;
    assign q_item.below = dist_reg < -band;
    assign q_item.last  = s2_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_last_reg <= s_tlast;
            px_reg      <= vx * cfg.normal_x;
            py_reg      <= vy * cfg.normal_y;
            pz_reg      <= vz * cfg.normal_z;
            s2_last_reg <= s1_last_reg;
            dist_reg    <= dist_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ppc_queue.sv -----
`default_nettype none

module ppc_queue
    import ppc_pkg::*;
#(
    parameter int DEPTH = PPC_FIFO_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  vclass_t   push_item,
    output logic      full,
    input  wire logic pop,
    output vclass_t   head_item,
    output logic      empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vclass_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign head_item = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ppc_back.sv -----
`default_nettype none

module ppc_back
    import ppc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  vclass_t                    head_item,
    input  wire logic                  q_empty,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata
);

    logic              all_front_reg;
    logic              all_back_reg;
    logic              all_on_reg;
    logic              all_front_next;
    logic              all_back_next;
    logic              all_on_next;
    logic              m_valid_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = !q_empty && (!head_item.last || out_free);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-SIDE_W){1'b0}}, side_reg};

    assign all_front_next = all_front_reg && !head_item.below;
    assign all_back_next  = all_back_reg && !head_item.above;
    assign all_on_next    = all_on_reg && !head_item.above && !head_item.below;

    always_comb begin
        if (all_on_next) begin
            side_next = SIDE_COPLANAR;
        end else if (all_back_next) begin
            side_next = SIDE_BACK;
        end else if (all_front_next) begin
            side_next = SIDE_FRONT;
        end else begin
            side_next = SIDE_CROSSING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            all_front_reg <= 1'b1;
            all_back_reg  <= 1'b1;
            all_on_reg    <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (head_item.last) begin
                    all_front_reg <= 1'b1;
                    all_back_reg  <= 1'b1;
                    all_on_reg    <= 1'b1;
                    m_valid_reg   <= 1'b1;
                end else begin
                    all_front_reg <= all_front_next;
                    all_back_reg  <= all_back_next;
                    all_on_reg    <= all_on_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && head_item.last) begin
            side_reg <= side_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/polygon_plane_classifier.sv -----
// Path: a last vertex's result passes the product, distance, queue and output
//   registers in turn before it shows on m_tvalid.
// Throughput: one vertex per cycle; the input side stalls only when the
//   classification queue is full, the output side drains it independently.
// Reset: aresetn synchronous active low; clears pipeline, queue and flags,
//   and loads the register defaults.
`default_nettype none

module polygon_plane_classifier
    import ppc_pkg::*;
#(
    parameter int FIFO_DEPTH = PPC_FIFO_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // vertex_x, vertex_y, vertex_z
    input  wire logic                  s_tlast,  // last_vertex
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,  // side, zero pad
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t    cfg;
    vclass_t push_item;
    vclass_t head_item;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;

    ppc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    ppc_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    ppc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ppc_checker.sv -----
`default_nettype none

module ppc_checker
    import ppc_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:SIDE_W] == '0)
        else $error("nonzero pad bits in result");

endmodule

bind polygon_plane_classifier ppc_checker u_ppc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/polygon_plane_classifier_tb.sv -----
`timescale 1ns / 1ps

module polygon_plane_classifier_tb;
    import ppc_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam longint Q_SCALE = 64'sd1 <<< FRAC_SHIFT;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

    typedef enum int {VTX_ON, VTX_FRONT, VTX_BACK, VTX_NOISE} vertex_kind_e;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;  // vertex_x, vertex_y, vertex_z
    logic s_tlast;                  // last_vertex
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // side, zero pad
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    cfg_t plane_cfg;
    logic flag_front = 1'b1;
    logic flag_back = 1'b1;
    logic flag_on = 1'b1;
    logic [SIDE_W-1:0] exp_sides[$];
    int mismatch_count = 0;
    int send_gap_pct = 32;
    int recv_stall_pct = 67;

    polygon_plane_classifier u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void predict_vertex(input logic signed [COORD_W-1:0] vx, vy, vz,
                                           input logic last);
        longint distance;
        longint band;
        logic [SIDE_W-1:0] side;
        distance = longint'(plane_cfg.normal_x) * longint'(vx)
                 + longint'(plane_cfg.normal_y) * longint'(vy)
                 + longint'(plane_cfg.normal_z) * longint'(vz)
                 - longint'(plane_cfg.plane_offset) * Q_SCALE;
        band = longint'(plane_cfg.tolerance) * Q_SCALE;
        if (distance > band) begin
            flag_back = 1'b0;
            flag_on = 1'b0;
        end else if (distance < -band) begin
            flag_front = 1'b0;
            flag_on = 1'b0;
        end
        if (last) begin
            if (flag_on)
                side = SIDE_COPLANAR;
            else if (flag_back)
                side = SIDE_BACK;
            else if (flag_front)
                side = SIDE_FRONT;
            else
                side = SIDE_CROSSING;
            exp_sides.push_back(side);
            flag_front = 1'b1;
            flag_back = 1'b1;
            flag_on = 1'b1;
        end
    endfunction

    // Picks x/y, then solves z so the vertex lands on, in front of or behind the plane; noise is random.
    function automatic void make_vertex(input vertex_kind_e kind,
                                        output logic signed [COORD_W-1:0] vx, vy, vz);
        longint nz;
        longint px;
        longint py;
        longint pz;
        longint target;
        longint step;
        longint span;
        longint dsign;
        nz = longint'(plane_cfg.normal_z);
        if (kind == VTX_NOISE || nz == 0) begin
            vx = $urandom();
            vy = $urandom();
            vz = $urandom();
            return;
        end
        if ($urandom_range(7) == 0) begin
            px = longint'(int'($urandom()));
            py = longint'(int'($urandom()));
        end else begin
            px = longint'($urandom_range(32'd2097152)) - 64'sd1048576;
            py = longint'($urandom_range(32'd2097152)) - 64'sd1048576;
        end
        target = longint'(plane_cfg.plane_offset) * Q_SCALE
               - longint'(plane_cfg.normal_x) * px
               - longint'(plane_cfg.normal_y) * py;
        pz = target / nz;
        step = longint'(plane_cfg.tolerance) * Q_SCALE / ((nz < 0) ? -nz : nz);
        dsign = (nz < 0) ? -64'sd1 : 64'sd1;
        case (kind)
            VTX_ON: begin
                if (step >= 2) begin
                    span = (step - 1 > 64'sd1073741824) ? 64'sd1073741824 : step - 1;
                    pz = pz + longint'($urandom_range(32'(2 * span))) - span;
                end
            end
            VTX_FRONT: pz = pz + dsign * (step + 2 + longint'($urandom_range(3)));
            VTX_BACK:  pz = pz - dsign * (step + 2 + longint'($urandom_range(3)));
            default: ;
        endcase
        if (pz > longint'(COORD_MAX))
            pz = longint'(COORD_MAX);
        if (pz < longint'(COORD_MIN))
            pz = longint'(COORD_MIN);
        vx = px[COORD_W-1:0];
        vy = py[COORD_W-1:0];
        vz = pz[COORD_W-1:0];
    endfunction

    task automatic send_vertex(input logic signed [COORD_W-1:0] vx, vy, vz, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {vz, vy, vx};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_vertex(vx, vy, vz, last);
    endtask

    // Holds off the sender until every pending side has come out, then lets the pipe empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (exp_sides.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        case (idx)
            REG_NORMAL_X:     plane_cfg.normal_x = value[NORMAL_W-1:0];
            REG_NORMAL_Y:     plane_cfg.normal_y = value[NORMAL_W-1:0];
            REG_NORMAL_Z:     plane_cfg.normal_z = value[NORMAL_W-1:0];
            REG_PLANE_OFFSET: plane_cfg.plane_offset = value[OFFSET_W-1:0];
            REG_TOLERANCE:    plane_cfg.tolerance = value[TOL_W-1:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_plane(input int nx, ny, nz, off, input int unsigned tol);
        drain_results();
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_PLANE_OFFSET, off);
        write_reg(REG_TOLERANCE, tol);
    endtask

    task automatic send_random_polygon(output int sent);
        int count;
        int intent;
        vertex_kind_e kind;
        logic signed [COORD_W-1:0] vx, vy, vz;
        count = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(6, 1);
        intent = $urandom_range(9);
        for (int i = 0; i < count; i++) begin
            case (intent)
                0, 1: kind = VTX_ON;
                2, 3: kind = ($urandom_range(3) == 0) ? VTX_ON : VTX_FRONT;
                4, 5: kind = ($urandom_range(3) == 0) ? VTX_ON : VTX_BACK;
                6, 7: kind = vertex_kind_e'($urandom_range(2));
                default: kind = VTX_NOISE;
            endcase
            make_vertex(kind, vx, vy, vz);
            send_vertex(vx, vy, vz, i == count - 1);
        end
        sent = count;
    endtask

    // Default plane is z = 0 with a band of 66 raw units; probes the band edges.
    task automatic test_default_plane();
        send_vertex(COORD_MAX, COORD_MIN, 0, 1'b1);
        send_vertex(COORD_MIN, COORD_MAX, 66, 1'b0);
        send_vertex(0, 0, -66, 1'b1);
        send_vertex(0, 0, 67, 1'b1);
        send_vertex(-1, -1, -67, 1'b1);
        send_vertex(0, 0, 67, 1'b0);
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(0, 0, -67, 1'b1);
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(0, 0, 67, 1'b1);
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(0, 0, -67, 1'b1);
    endtask

    task automatic test_extreme_plane();
        set_plane(-16384, 16384, -16384, 32'sh80000000, 32'h7fffffff);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(0, 0, 0, 1'b1);
    endtask

    // Zero band: only an exact zero distance is on the plane.
    task automatic test_zero_tolerance();
        set_plane(16384, 1, 0, 32'sh7fffffff, 0);
        send_vertex(COORD_MAX, 0, 0, 1'b1);
        send_vertex(COORD_MAX - 1, 0, 0, 1'b1);
        send_vertex(COORD_MAX, 1, 0, 1'b1);
    endtask

    task automatic test_unused_register();
        drain_results();
        write_reg(REG_UNUSED, 32'hffffffff);
        send_vertex(COORD_MAX, 0, 0, 1'b1);
    endtask

    task automatic test_random_planes(input int n_items);
        int done;
        int sent;
        int nx, ny, nz, off;
        int unsigned tol;
        for (int p = 0; p < 4; p++) begin
            case ($urandom_range(2))
                0: begin
                    nx = 0;
                    ny = 0;
                    nz = $urandom_range(1) ? 16384 : -16384;
                end
                1: begin
                    nx = int'($urandom_range(32768)) - 16384;
                    ny = int'($urandom_range(32768)) - 16384;
                    nz = int'($urandom_range(32768)) - 16384;
                end
                default: begin
                    nx = (int'($urandom_range(2)) - 1) * 16384;
                    ny = (int'($urandom_range(2)) - 1) * 16384;
                    nz = (int'($urandom_range(2)) - 1) * 16384;
                end
            endcase
            off = $urandom_range(1) ? int'($urandom_range(2097152)) - 1048576 : int'($urandom());
            case ($urandom_range(3))
                0: tol = 0;
                1: tol = $urandom_range(1000);
                2: tol = $urandom_range(1048576);
                default: tol = $urandom_range(32'h7fffffff);
            endcase
            set_plane(nx, ny, nz, off, tol);
            done = 0;
            while (done < n_items / 4) begin
                send_random_polygon(sent);
                done += sent;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (exp_sides.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %0h", $time, m_tdata);
                    mismatch_count++;
                end else if (m_tdata != {{(M_TDATA_W - SIDE_W){1'b0}}, exp_sides[0]}) begin
                    $display("%0t: side mismatch, expected %0h, actual %0h",
                             $time, exp_sides[0], m_tdata);
                    mismatch_count++;
                    void'(exp_sides.pop_front());
                end else begin
                    void'(exp_sides.pop_front());
                end
            end
        end
    end

    initial begin
        plane_cfg = '{NORMAL_X_RST, NORMAL_Y_RST, NORMAL_Z_RST, OFFSET_RST, TOL_RST};
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_plane();
        test_extreme_plane();
        test_zero_tolerance();
        test_unused_register();
        test_random_planes(360);
        send_gap_pct = 67;
        recv_stall_pct = 32;
        test_random_planes(360);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random_planes(360);

        drain_results();
        if (mismatch_count == 0)
            $display("polygon_plane_classifier: match");
        else
            $display("polygon_plane_classifier: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("polygon_plane_classifier: mismatch");
        $finish;
    end

endmodule
